[hw/rtl/source_address_select_assert.svh]
// Assertion macros for the source address selection block.
// Used by source_address_select.sv; expects clk and rst_n in scope.
`ifndef SOURCE_ADDRESS_SELECT_ASSERT_SVH
`define SOURCE_ADDRESS_SELECT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("source address select: check failed");

// Next-cycle implication, disabled during reset.
`define SAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("source address select: check failed");

`endif

[hw/rtl/sas_pkg.sv]
// Types and constants for the source address selection block.
// No dependencies; used by sas_prefix_cmp and source_address_select.
`timescale 1ns / 1ps
`default_nettype none

package sas_pkg;

    localparam int ADDR_W = 128;

    localparam logic [1:0] OP_WRITE_SLOT = 2'd0;
    localparam logic [1:0] OP_WRITE_LL   = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    // fe80::/10 and ff02::/32 prefixes, compared against the upper half
    localparam logic [9:0]  LL_UNICAST_PREFIX   = 10'h3fa;
    localparam logic [31:0] LL_MULTICAST_PREFIX = 32'hff020000;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  slot;
        logic [3:0]  iface;
        logic        is_v6;
        logic        entry_valid;
        logic        stale;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
    } result_t;

    // One table word as stored in the entry RAM
    typedef struct packed {
        logic        is_v6;
        logic        stale;
        logic        valid;
        logic [3:0]  iface;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LL_RD,
        S_LL_OUT,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/sas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/sas_prefix_cmp.sv]
// Shared prefix-length comparator for the table walk.
// Depends on sas_pkg for the address width.
`timescale 1ns / 1ps
`default_nettype none

module sas_prefix_cmp (
    input  wire logic [sas_pkg::ADDR_W-1:0] a,
    input  wire logic [sas_pkg::ADDR_W-1:0] b,
    output logic                            a_longer
);

    // a and b are XORs against the destination. a has more leading zeros than b
    // exactly when b's top set bit lies above every bit of a, i.e. a < (b & ~a).
    assign a_longer = a < (b & ~a);

endmodule

`default_nettype wire

[hw/rtl/source_address_select.sv]
// Top level of the source address selection block: sequencer, tables, result.
// Depends on sas_pkg, sas_ram, sas_prefix_cmp and source_address_select_assert.svh.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+---------------------------------------
//  command  | item, start, busy     | beat taken when start && !busy
//  result   | result, done          | one-cycle strobe, no back-pressure
//
// Writes (table slot, link-local) give no result.
// A link-local query passes S_LL_RD and S_LL_OUT before it answers; a table query
// walks every slot through the entry RAM read port, one per cycle, and then passes
// S_DRAIN and S_FINISH before it answers.
// After reset a clearing pass over every table slot holds busy high.
// busy stays high from query acceptance until the result strobe.
`timescale 1ns / 1ps
`default_nettype none

module source_address_select #(
    parameter int TABLE_ENTRIES = 64,
    parameter int INTERFACES    = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sas_pkg::item_t    item,
    output logic                   done,
    output sas_pkg::result_t       result
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam int EW = $bits(sas_pkg::entry_t);

    sas_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    sas_pkg::item_t   q_reg;
    logic             pend_reg;
    logic             have_reg;
    logic [sas_pkg::ADDR_W-1:0] best_x_reg;
    logic [63:0]      best_hi_reg, best_lo_reg;
    logic             done_reg;
    sas_pkg::result_t result_reg, result_next;
    logic             res_load;
    logic [INTERFACES-1:0] ll_valid_reg;

    // entry RAM
    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    logic [EW-1:0]    tbl_wdata;
    logic [EW-1:0]    tbl_rdata;
    sas_pkg::entry_t  ent;

    // link-local RAM
    logic             ll_we;
    logic [LW-1:0]    ll_waddr;
    logic [LW-1:0]    ll_raddr;
    logic [127:0]     ll_rdata;

    logic             accept;
    logic             item_ll_dest;
    logic             slot_in_range;
    logic             wr_iface_in_range;
    logic             q_iface_in_range;
    logic             ent_match;
    logic [sas_pkg::ADDR_W-1:0] cur_x;
    logic [sas_pkg::ADDR_W-1:0] cmp_a, cmp_b;
    logic             cmp_longer;
    logic             take;

    sas_pkg::entry_t  wr_entry;

    assign accept = start && (state_reg == sas_pkg::S_IDLE);
    assign busy   = (state_reg != sas_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign item_ll_dest = item.is_v6 &&
        ((item.addr_hi[63:54] == sas_pkg::LL_UNICAST_PREFIX) ||
         (item.addr_hi[63:32] == sas_pkg::LL_MULTICAST_PREFIX));
    assign slot_in_range     = 32'(item.slot) < 32'(TABLE_ENTRIES);
    assign wr_iface_in_range = 32'(item.iface) < 32'(INTERFACES);
    assign q_iface_in_range  = 32'(q_reg.iface) < 32'(INTERFACES);

    always_comb
    begin
        wr_entry.is_v6   = item.is_v6;
        wr_entry.stale   = item.stale;
        wr_entry.valid   = item.entry_valid;
        wr_entry.iface   = item.iface;
        wr_entry.addr_hi = item.addr_hi;
        wr_entry.addr_lo = item.addr_lo;
    end

    // clearing pass owns the write port until the block goes idle
    always_comb
    begin
        if (state_reg == sas_pkg::S_CLEAR)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = idx_reg;
            tbl_wdata = '0;
        end
        else
        begin
            tbl_we    = accept && (item.op == sas_pkg::OP_WRITE_SLOT) && slot_in_range;
            tbl_waddr = AW'(item.slot);
            tbl_wdata = wr_entry;
        end
    end

    assign ll_we    = accept && (item.op == sas_pkg::OP_WRITE_LL) && wr_iface_in_range;
    assign ll_waddr = LW'(item.iface);
    assign ll_raddr = LW'(q_reg.iface);

    sas_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (idx_reg),
        .rdata (tbl_rdata)
    );

    sas_ram #(
        .WIDTH (128),
        .DEPTH (INTERFACES)
    ) u_ll_ram (
        .clk   (clk),
        .we    (ll_we),
        .waddr (ll_waddr),
        .wdata ({item.addr_hi, item.addr_lo}),
        .raddr (ll_raddr),
        .rdata (ll_rdata)
    );

    // evaluate the entry read in the previous cycle
    assign ent = sas_pkg::entry_t'(tbl_rdata);
    assign ent_match = pend_reg && ent.valid && !ent.stale &&
                       (ent.iface == q_reg.iface) && (ent.is_v6 == q_reg.is_v6);

    always_comb
    begin
        if (q_reg.is_v6)
        begin
            cur_x = {ent.addr_hi ^ q_reg.addr_hi, ent.addr_lo ^ q_reg.addr_lo};
            cmp_a = cur_x;
            cmp_b = best_x_reg;
        end
        else
        begin
            cur_x = {96'b0, ent.addr_lo[31:0] ^ q_reg.addr_lo[31:0]};
            cmp_a = best_x_reg;
            cmp_b = cur_x;
        end
    end

    sas_prefix_cmp u_cmp (
        .a        (cmp_a),
        .b        (cmp_b),
        .a_longer (cmp_longer)
    );

    // IPv6 keeps the first on a tie, IPv4 takes the last
    assign take = ent_match &&
                  (!have_reg || (q_reg.is_v6 ? cmp_longer : !cmp_longer));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        res_load    = 1'b0;
        result_next = '0;
        unique case (state_reg)
            sas_pkg::S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = sas_pkg::S_IDLE;
                end
            end
            sas_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (accept && (item.op == sas_pkg::OP_QUERY))
                begin
                    state_next = item_ll_dest ? sas_pkg::S_LL_RD : sas_pkg::S_WALK;
                end
            end
            sas_pkg::S_LL_RD:
            begin
                state_next = sas_pkg::S_LL_OUT;
            end
            sas_pkg::S_LL_OUT:
            begin
                res_load = 1'b1;
                if (q_iface_in_range && ll_valid_reg[ll_raddr])
                begin
                    result_next.found  = 1'b1;
                    result_next.src_hi = ll_rdata[127:64];
                    result_next.src_lo = ll_rdata[63:0];
                end
                state_next = sas_pkg::S_IDLE;
            end
            sas_pkg::S_WALK:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = sas_pkg::S_DRAIN;
                end
            end
            sas_pkg::S_DRAIN:
            begin
                state_next = sas_pkg::S_FINISH;
            end
            sas_pkg::S_FINISH:
            begin
                res_load = 1'b1;
                if (have_reg)
                begin
                    result_next.found  = 1'b1;
                    result_next.src_hi = best_hi_reg;
                    result_next.src_lo = best_lo_reg;
                end
                state_next = sas_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sas_pkg::S_CLEAR;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            have_reg     <= 1'b0;
            done_reg     <= 1'b0;
            ll_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= (state_reg == sas_pkg::S_WALK);
            done_reg  <= res_load;
            if (ll_we)
            begin
                ll_valid_reg[ll_waddr] <= item.entry_valid;
            end
            if (accept)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept && (item.op == sas_pkg::OP_QUERY))
        begin
            q_reg <= item;
        end
        if (take)
        begin
            best_x_reg  <= cur_x;
            best_hi_reg <= q_reg.is_v6 ? ent.addr_hi : 64'b0;
            best_lo_reg <= q_reg.is_v6 ? ent.addr_lo : {32'b0, ent.addr_lo[31:0]};
        end
        if (res_load)
        begin
            result_reg <= result_next;
        end
    end

`include "source_address_select_assert.svh"

    `SAS_ASSERT_NEXT(a_query_busy, accept && (item.op == sas_pkg::OP_QUERY), busy)
    `SAS_ASSERT_NEXT(a_finish_done,
        (state_reg == sas_pkg::S_FINISH) || (state_reg == sas_pkg::S_LL_OUT), done)
    `SAS_ASSERT_NOW(a_miss_zero, done && !result.found,
        (result.src_hi == 64'b0) && (result.src_lo == 64'b0))
    `SAS_ASSERT_NOW(a_v4_upper_zero, done && !q_reg.is_v6,
        (result.src_hi == 64'b0) && (result.src_lo[63:32] == 32'b0))

endmodule

`default_nettype wire

[tb/sv/sas_lookup_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for source_address_select: mirrors the address tables from the
// command beats it sees and checks every lookup answer. Depends on sas_pkg.
module sas_lookup_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire sas_pkg::item_t   item,
    input  wire logic             done,
    input  wire sas_pkg::result_t result,
    output int                    mismatches,
    output int                    outstanding,
    output int                    hits
);
    import sas_pkg::*;

    localparam int SLOTS  = 64;
    localparam int IFACES = 16;

    logic         slot_valid [SLOTS];
    logic         slot_v6    [SLOTS];
    logic         slot_stale [SLOTS];
    logic [3:0]   slot_iface [SLOTS];
    logic [127:0] slot_addr  [SLOTS];
    logic         ll_valid   [IFACES];
    logic [127:0] ll_addr    [IFACES];

    result_t answers_due [$];
    result_t want;

    // Count equal leading bits; diff holds the XOR in its low width bits.
    function automatic int leading_match(logic [127:0] diff, int width);
        int n;
        n = 0;
        while (n < width && !diff[width - 1 - n])
            n++;
        return n;
    endfunction

    function automatic result_t select_source(item_t q);
        result_t      ans;
        logic [127:0] dest;
        int           best_len;
        int           len;
        int           s;
        bit           have;
        ans      = '0;
        dest     = {q.addr_hi, q.addr_lo};
        have     = 1'b0;
        best_len = 0;
        // Link-local and link-scope multicast destinations bypass the table
        if (q.is_v6 && (q.addr_hi[63:54] == LL_UNICAST_PREFIX ||
                        q.addr_hi[63:32] == LL_MULTICAST_PREFIX))
        begin
            if (ll_valid[q.iface])
            begin
                ans.found = 1'b1;
                {ans.src_hi, ans.src_lo} = ll_addr[q.iface];
            end
            return ans;
        end
        for (s = 0; s < SLOTS; s++)
        begin
            if (!slot_valid[s] || slot_stale[s] || slot_iface[s] != q.iface ||
                slot_v6[s] != q.is_v6)
                continue;
            if (q.is_v6)
            begin
                len = leading_match(slot_addr[s] ^ dest, 128);
                // keep the first entry on a tie
                if (!have || len > best_len)
                begin
                    have     = 1'b1;
                    best_len = len;
                    {ans.src_hi, ans.src_lo} = slot_addr[s];
                end
            end
            else
            begin
                len = leading_match({96'd0, slot_addr[s][31:0] ^ dest[31:0]}, 32);
                // take the last entry on a tie
                if (!have || len >= best_len)
                begin
                    have       = 1'b1;
                    best_len   = len;
                    ans.src_hi = '0;
                    ans.src_lo = {32'd0, slot_addr[s][31:0]};
                end
            end
        end
        ans.found = have;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_valid[i] = 1'b0;
            for (int i = 0; i < IFACES; i++)
                ll_valid[i] = 1'b0;
            answers_due.delete();
            mismatches  = 0;
            hits        = 0;
            outstanding = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("lookup answer with no lookup pending");
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, result.found);
                        mismatches++;
                    end
                    if (result.src_hi !== want.src_hi)
                    begin
                        $error("src_hi: expected %h, actual %h", want.src_hi, result.src_hi);
                        mismatches++;
                    end
                    if (result.src_lo !== want.src_lo)
                    begin
                        $error("src_lo: expected %h, actual %h", want.src_lo, result.src_lo);
                        mismatches++;
                    end
                    if (want.found)
                        hits++;
                end
            end

            if (start === 1'b1 && busy === 1'b0)
            begin
                case (item.op)
                    OP_WRITE_SLOT:
                    begin
                        slot_valid[item.slot] = item.entry_valid;
                        slot_v6[item.slot]    = item.is_v6;
                        slot_stale[item.slot] = item.stale;
                        slot_iface[item.slot] = item.iface;
                        slot_addr[item.slot]  = {item.addr_hi, item.addr_lo};
                    end
                    OP_WRITE_LL:
                    begin
                        ll_valid[item.iface] = item.entry_valid;
                        ll_addr[item.iface]  = {item.addr_hi, item.addr_lo};
                    end
                    OP_QUERY:
                        answers_due.push_back(select_source(item));
                    default: ;
                endcase
            end
            outstanding = answers_due.size();
        end
    end

endmodule

[tb/sv/tb_source_address_select.sv]
`timescale 1ns / 1ps
// Testbench top for source_address_select: drives command beats and gives the
// verdict. Depends on sas_pkg, the RTL and sas_lookup_checker.
module tb_source_address_select;
    import sas_pkg::*;

    localparam int         RANDOM_BEATS = 1850;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    done;
    item_t   item;
    result_t result;

    int mismatches;
    int outstanding;
    int hits;
    int n_slot_wr;
    int n_ll_wr;
    int n_lookup;
    int n_dropped;

    logic [127:0] prefix_pool [4];

    source_address_select uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    sas_lookup_checker lookup_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .hits        (hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic item_t mk(logic [1:0] op, int slot, int iface, bit v6, bit valid,
                                 bit stale, logic [63:0] hi, logic [63:0] lo);
        item_t b;
        b.op          = op;
        b.slot        = slot[5:0];
        b.iface       = iface[3:0];
        b.is_v6       = v6;
        b.entry_valid = valid;
        b.stale       = stale;
        b.addr_hi     = hi;
        b.addr_lo     = lo;
        return b;
    endfunction

    // Favor a few interfaces so lookups find several candidates
    function automatic logic [3:0] pick_iface();
        if ($urandom_range(0, 3) != 0)
            return 4'($urandom_range(0, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [127:0] near_pool();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return prefix_pool[$urandom_range(0, 3)] ^ (r >> $urandom_range(0, 128));
    endfunction

    function automatic logic [31:0] near_v4();
        logic [31:0] r;
        r = $urandom;
        return prefix_pool[$urandom_range(0, 3)][31:0] ^ (r >> $urandom_range(0, 32));
    endfunction

    function automatic item_t rand_beat();
        item_t        b;
        logic [127:0] a;
        logic [127:0] r;
        int           pick;
        b.slot        = 6'($urandom_range(0, 63));
        b.iface       = pick_iface();
        b.is_v6       = 1'($urandom_range(0, 1));
        b.entry_valid = ($urandom_range(0, 7) != 0);
        b.stale       = ($urandom_range(0, 6) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            b.op = OP_WRITE_SLOT;
        else if (pick < 50)
            b.op = OP_WRITE_LL;
        else if (pick < 96)
            b.op = OP_QUERY;
        else
            b.op = OP_UNUSED;
        r = {$urandom, $urandom, $urandom, $urandom};
        if (b.op == OP_WRITE_LL)
            a = {LL_UNICAST_PREFIX, r[117:0]};
        else if (b.op == OP_QUERY && $urandom_range(0, 4) == 0)
            a = $urandom_range(0, 1) ? {LL_UNICAST_PREFIX, r[117:0]}
                                     : {LL_MULTICAST_PREFIX, r[95:0]};
        else if (b.is_v6)
            a = near_pool();
        else
            a = {r[127:32], near_v4()};
        {b.addr_hi, b.addr_lo} = a;
        return b;
    endfunction

    // Hold the beat until the block takes it at a rising edge with busy low
    task automatic send_beat(input item_t it, input int gap);
        logic [159:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            item  <= junk[$bits(item_t)-1:0];
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        case (it.op)
            OP_WRITE_SLOT: n_slot_wr++;
            OP_WRITE_LL:   n_ll_wr++;
            OP_QUERY:      n_lookup++;
            default:       n_dropped++;
        endcase
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 && n < 1000)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    initial
    begin
        item_t plan [$];
        item_t b;
        int    useful;
        bit    burst;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        n_slot_wr = 0;
        n_ll_wr   = 0;
        n_lookup  = 0;
        n_dropped = 0;
        for (int i = 0; i < 4; i++)
            prefix_pool[i] = {$urandom, $urandom, $urandom, $urandom};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty tables, then link-local entries
        plan.push_back(mk(OP_QUERY, 0, 3, 1, 0, 0, 64'h2001_0db8_0000_0000, 64'h1));
        plan.push_back(mk(OP_QUERY, 0, 3, 0, 0, 0, 64'h0, 64'hc0a8_0001));
        plan.push_back(mk(OP_QUERY, 0, 3, 1, 0, 0, 64'hfe80_0000_0000_0000, 64'h1));
        plan.push_back(mk(OP_WRITE_LL, 0, 3, 1, 1, 0, 64'hfe80_0000_0000_0000,
                          64'h0211_22ff_fe33_4455));
        plan.push_back(mk(OP_WRITE_LL, 0, 15, 1, 1, 0, '1, '1));
        plan.push_back(mk(OP_QUERY, 0, 3, 1, 0, 0, 64'hfe80_0000_0000_0000, 64'h9));
        plan.push_back(mk(OP_QUERY, 0, 15, 1, 0, 0, 64'hff02_0000_0000_0000, 64'h1));
        plan.push_back(mk(OP_QUERY, 0, 0, 1, 0, 0, 64'hfe80_0000_0000_0000, 64'h1));
        // IPv6 tie keeps the first slot
        plan.push_back(mk(OP_WRITE_SLOT, 0, 3, 1, 1, 0, 64'h2001_0db8_0000_0000, 64'h1));
        plan.push_back(mk(OP_WRITE_SLOT, 1, 3, 1, 1, 0, 64'h2001_0db8_0000_0000, 64'h2));
        plan.push_back(mk(OP_QUERY, 0, 3, 1, 0, 0, 64'h2001_0db8_0000_0000, 64'h4));
        // IPv4 tie takes the last slot; upper bits are noise
        plan.push_back(mk(OP_WRITE_SLOT, 2, 3, 0, 1, 0, '1, 64'hdead_beef_c0a8_0001));
        plan.push_back(mk(OP_WRITE_SLOT, 3, 3, 0, 1, 0, 64'h0, 64'hc0a8_0002));
        plan.push_back(mk(OP_QUERY, 0, 3, 0, 0, 0, '1, 64'h1234_5678_c0a8_0004));
        // stale exact match is skipped, invalidated slot drops out
        plan.push_back(mk(OP_WRITE_SLOT, 4, 3, 1, 1, 1, 64'h2001_0db8_0000_0000, 64'h4));
        plan.push_back(mk(OP_QUERY, 0, 3, 1, 0, 0, 64'h2001_0db8_0000_0000, 64'h4));
        plan.push_back(mk(OP_WRITE_SLOT, 0, 3, 1, 0, 0, 64'h2001_0db8_0000_0000, 64'h1));
        plan.push_back(mk(OP_QUERY, 0, 3, 1, 0, 0, 64'h2001_0db8_0000_0000, 64'h4));
        plan.push_back(mk(OP_UNUSED, 63, 15, 1, 1, 1, '1, '1));
        // extremes: top slot, top interface, all-ones and all-zero addresses
        plan.push_back(mk(OP_WRITE_SLOT, 63, 15, 1, 1, 0, '1, '1));
        plan.push_back(mk(OP_QUERY, 0, 15, 1, 0, 0, 64'h0, 64'h0));
        plan.push_back(mk(OP_QUERY, 0, 15, 1, 0, 0, 64'hfec0_0000_0000_0000, 64'h0));
        plan.push_back(mk(OP_QUERY, 0, 15, 1, 0, 0, 64'hff02_0001_0000_0000, 64'h0));
        plan.push_back(mk(OP_WRITE_SLOT, 62, 0, 0, 1, 0, 64'h0, '1));
        plan.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 64'hfe80_0000_0000_0000, 64'h0));
        plan.push_back(mk(OP_WRITE_LL, 0, 3, 1, 0, 0, 64'hfe80_0000_0000_0000, 64'h5));
        plan.push_back(mk(OP_QUERY, 0, 3, 1, 0, 0, 64'hfe80_0000_0000_0000, 64'h1));

        foreach (plan[i])
            send_beat(plan[i], $urandom_range(0, 7));
        wait_drained();

        useful = 0;
        while (useful < RANDOM_BEATS)
        begin
            b     = rand_beat();
            burst = ((useful / 150) % 4 == 3);
            send_beat(b, burst ? 0 : $urandom_range(0, 7));
            if (b.op != OP_UNUSED)
            begin
                useful++;
                if (useful % 300 == 0)
                    wait_drained();
                if (useful % 400 == 0)
                    prefix_pool[$urandom_range(0, 3)] = {$urandom, $urandom, $urandom, $urandom};
            end
        end

        wait_drained();
        repeat (80) @(posedge clk);

        $display("Sent %0d slot writes, %0d link-local writes, %0d lookups, %0d unused-op beats.",
                 n_slot_wr, n_ll_wr, n_lookup, n_dropped);
        $display("%0d lookups returned a source address, the rest returned none.", hits);
        if (outstanding != 0)
            $error("%0d lookups never answered", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
